### rtl/core/cptr_pkg.sv
// ----------------------------------------------------------------------------
// cptr_pkg: shared widths and types of the two-line closest point pipeline
// Word widths of every intermediate product, sum and divider register.
// ----------------------------------------------------------------------------
package cptr_pkg;

  localparam int PW   = 32;   // point coordinate, Q16.16
  localparam int DW   = 16;   // direction component, Q1.14
  localparam int NAX  = 3;    // number of axes
  localparam int WW   = 33;   // point difference and point sum
  localparam int SQW  = 32;   // direction products
  localparam int ABW  = 33;   // a, b and c
  localparam int WDW  = 48;   // one term of d or e
  localparam int DEW  = 50;   // d and e
  localparam int MW   = 66;   // a*c, b*b and the partial products with den
  localparam int DENW = 65;   // determinant
  localparam int SPLW = 25;   // low slice of d and e
  localparam int PPW  = 59;   // partial products of the numerators
  localparam int PRW  = 83;   // b*e, c*d, a*e and b*d
  localparam int SNW  = 85;   // s and t numerators
  localparam int DLO  = 32;   // low slice of den
  localparam int CHK  = 28;   // slice of a numerator
  localparam int CPW  = 45;   // numerator slice times direction
  localparam int TW   = 104;  // biased total
  localparam int DVW  = 66;   // divisor, twice den
  localparam int RW   = 98;   // divider remainder
  localparam int QW   = 32;   // quotient

  localparam logic signed [PW-1:0] MID_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] MID_MIN = {1'b1, {(PW-1){1'b0}}};

  typedef struct packed {
    logic           par;
    logic [NAX-1:0] lo;
    logic [NAX-1:0] hi;
  } cptr_flags_t;

endpackage

### rtl/core/closest_point_two_rays.sv
// ----------------------------------------------------------------------------
// closest_point_two_rays: midpoint of the closest points of two 3D lines
// Dot products, determinant, numerators and a biased total per axis, then a
// radix-2 restoring divider that yields the saturated Q16.16 midpoint.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; ten arithmetic stages, one range check stage,
// thirty-two divider steps (one quotient bit each) and the output register.
// The whole pipeline advances together and halts while an output word stalls.
// Reset clears only the valid bits; data registers are not reset.
module closest_point_two_rays (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [cptr_pkg::PW-1:0]     pa_x_i,
  input  logic signed [cptr_pkg::PW-1:0]     pa_y_i,
  input  logic signed [cptr_pkg::PW-1:0]     pa_z_i,
  input  logic signed [cptr_pkg::DW-1:0]     da_x_i,
  input  logic signed [cptr_pkg::DW-1:0]     da_y_i,
  input  logic signed [cptr_pkg::DW-1:0]     da_z_i,
  input  logic signed [cptr_pkg::PW-1:0]     pb_x_i,
  input  logic signed [cptr_pkg::PW-1:0]     pb_y_i,
  input  logic signed [cptr_pkg::PW-1:0]     pb_z_i,
  input  logic signed [cptr_pkg::DW-1:0]     db_x_i,
  input  logic signed [cptr_pkg::DW-1:0]     db_y_i,
  input  logic signed [cptr_pkg::DW-1:0]     db_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [cptr_pkg::PW-1:0]     mid_x_o,
  output logic signed [cptr_pkg::PW-1:0]     mid_y_o,
  output logic signed [cptr_pkg::PW-1:0]     mid_z_o,
  output logic                               parallel_flag_o,
  output logic                               clipped_flag_o
);
  import cptr_pkg::*;

  localparam int NS = 44;

  logic          en;
  logic [NS:1]   v_q;

  logic signed [PW-1:0] pa [NAX];
  logic signed [PW-1:0] pb [NAX];
  logic signed [DW-1:0] da [NAX];
  logic signed [DW-1:0] db [NAX];

  // Stage 1 to 3: differences, sums, dot products.
  logic signed [WW-1:0]  s1_w_q [NAX], s1_sp_q [NAX];
  logic signed [DW-1:0]  s1_da_q [NAX], s1_db_q [NAX];
  logic signed [SQW-1:0] s1_aa_q [NAX], s1_ab_q [NAX], s1_bb_q [NAX];

  logic signed [ABW-1:0] s2_a_q, s2_b_q, s2_c_q;
  logic signed [WDW-1:0] s2_wd_q [NAX], s2_we_q [NAX];
  logic signed [WW-1:0]  s2_sp_q [NAX];
  logic signed [DW-1:0]  s2_da_q [NAX], s2_db_q [NAX];

  logic signed [ABW-1:0] s3_a_q, s3_b_q, s3_c_q;
  logic signed [DEW-1:0] s3_d_q, s3_e_q;
  logic signed [MW-1:0]  s3_ac_q, s3_bb_q;
  logic signed [WW-1:0]  s3_sp_q [NAX];
  logic signed [DW-1:0]  s3_da_q [NAX], s3_db_q [NAX];

  // Stage 4 to 6: determinant and the two numerators.
  logic signed [SPLW:0]     d_lo, e_lo;
  logic signed [SPLW-1:0]   d_hi, e_hi;
  logic signed [DENW-1:0]   s4_den_q;
  logic signed [PPW-1:0]    s4_be_lo_q, s4_be_hi_q, s4_cd_lo_q, s4_cd_hi_q;
  logic signed [PPW-1:0]    s4_ae_lo_q, s4_ae_hi_q, s4_bd_lo_q, s4_bd_hi_q;
  logic signed [WW-1:0]     s4_sp_q [NAX];
  logic signed [DW-1:0]     s4_da_q [NAX], s4_db_q [NAX];

  logic signed [DENW-1:0]   s5_den_q;
  logic signed [PRW-1:0]    s5_be_q, s5_cd_q, s5_ae_q, s5_bd_q;
  logic signed [WW-1:0]     s5_sp_q [NAX];
  logic signed [DW-1:0]     s5_da_q [NAX], s5_db_q [NAX];

  logic signed [DENW-1:0]   s6_den_q;
  logic signed [SNW-1:0]    s6_sn_q, s6_tn_q;
  logic signed [WW-1:0]     s6_sp_q [NAX];
  logic signed [DW-1:0]     s6_da_q [NAX], s6_db_q [NAX];

  // Stage 7 to 10: biased total per axis.
  logic signed [WW-1:0]     den_lo, den_hi;
  logic signed [CHK:0]      sn_c [3];
  logic signed [CHK:0]      tn_c [3];
  logic signed [DENW-1:0]   s7_den_q;
  logic signed [MW-1:0]     s7_pl_q [NAX], s7_ph_q [NAX];
  logic signed [CPW-1:0]    s7_ps_q [NAX][3];
  logic signed [CPW-1:0]    s7_pt_q [NAX][3];

  logic signed [DENW-1:0]   s8_den_q;
  logic signed [TW-1:0]     s8_p1_q [NAX], s8_p2_q [NAX], s8_p3_q [NAX];

  logic signed [DENW-1:0]   s9_den_q;
  logic signed [TW-1:0]     s9_x_q [NAX], s9_y_q [NAX];

  logic signed [DENW-1:0]   s10_den_q;
  logic signed [TW-1:0]     s10_nb_q [NAX];

  // Divider: index 0 is the range check stage, index QW the last step.
  logic [DVW-1:0]  dvsr;
  logic [TW-1:0]   lim;
  logic [RW-1:0]   dv_rem_q [QW+1][NAX];
  logic [RW-1:0]   dv_rem_d [QW+1][NAX];
  logic [QW-1:0]   dv_quo_q [QW+1][NAX];
  logic [QW-1:0]   dv_quo_d [QW+1][NAX];
  logic [DVW-1:0]  dv_d_q   [QW+1];
  cptr_flags_t     dv_fl_q  [QW+1];
  logic [RW:0]     trial;

  logic signed [PW-1:0] mid_q [NAX];
  logic signed [PW-1:0] mid_d [NAX];
  logic                 par_q, clip_q;

  assign en          = !v_q[NS] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = v_q[NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-1:1], in_valid_i};
    end
  end

  always_comb begin
    pa[0] = pa_x_i; pa[1] = pa_y_i; pa[2] = pa_z_i;
    pb[0] = pb_x_i; pb[1] = pb_y_i; pb[2] = pb_z_i;
    da[0] = da_x_i; da[1] = da_y_i; da[2] = da_z_i;
    db[0] = db_x_i; db[1] = db_y_i; db[2] = db_z_i;
  end

  // Slices that keep every multiplier near 32 by 32 bits.
  always_comb begin
    d_lo   = $signed({1'b0, s3_d_q[SPLW-1:0]});
    e_lo   = $signed({1'b0, s3_e_q[SPLW-1:0]});
    d_hi   = $signed(s3_d_q[DEW-1:SPLW]);
    e_hi   = $signed(s3_e_q[DEW-1:SPLW]);
    den_lo = $signed({1'b0, s6_den_q[DLO-1:0]});
    den_hi = $signed(s6_den_q[DENW-1:DLO]);
    sn_c[0] = $signed({1'b0, s6_sn_q[CHK-1:0]});
    sn_c[1] = $signed({1'b0, s6_sn_q[2*CHK-1:CHK]});
    sn_c[2] = $signed(s6_sn_q[SNW-1:2*CHK]);
    tn_c[0] = $signed({1'b0, s6_tn_q[CHK-1:0]});
    tn_c[1] = $signed({1'b0, s6_tn_q[2*CHK-1:CHK]});
    tn_c[2] = $signed(s6_tn_q[SNW-1:2*CHK]);
    dvsr   = {s10_den_q[DVW-2:0], 1'b0};
    lim    = TW'({dvsr, {QW{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NAX; i++) begin
        s1_w_q[i]  <= WW'(pa[i]) - WW'(pb[i]);
        s1_sp_q[i] <= WW'(pa[i]) + WW'(pb[i]);
        s1_da_q[i] <= da[i];
        s1_db_q[i] <= db[i];
        s1_aa_q[i] <= SQW'(da[i]) * SQW'(da[i]);
        s1_ab_q[i] <= SQW'(da[i]) * SQW'(db[i]);
        s1_bb_q[i] <= SQW'(db[i]) * SQW'(db[i]);

        s2_wd_q[i] <= WDW'(s1_w_q[i]) * WDW'(s1_da_q[i]);
        s2_we_q[i] <= WDW'(s1_w_q[i]) * WDW'(s1_db_q[i]);
        s2_sp_q[i] <= s1_sp_q[i];
        s2_da_q[i] <= s1_da_q[i];
        s2_db_q[i] <= s1_db_q[i];

        s3_sp_q[i] <= s2_sp_q[i];
        s3_da_q[i] <= s2_da_q[i];
        s3_db_q[i] <= s2_db_q[i];
        s4_sp_q[i] <= s3_sp_q[i];
        s4_da_q[i] <= s3_da_q[i];
        s4_db_q[i] <= s3_db_q[i];
        s5_sp_q[i] <= s4_sp_q[i];
        s5_da_q[i] <= s4_da_q[i];
        s5_db_q[i] <= s4_db_q[i];
        s6_sp_q[i] <= s5_sp_q[i];
        s6_da_q[i] <= s5_da_q[i];
        s6_db_q[i] <= s5_db_q[i];

        s7_pl_q[i] <= MW'(s6_sp_q[i]) * MW'(den_lo);
        s7_ph_q[i] <= MW'(s6_sp_q[i]) * MW'(den_hi);
        for (int k = 0; k < 3; k++) begin
          s7_ps_q[i][k] <= CPW'(sn_c[k]) * CPW'(s6_da_q[i]);
          s7_pt_q[i][k] <= CPW'(tn_c[k]) * CPW'(s6_db_q[i]);
        end

        s8_p1_q[i] <= (TW'(s7_ph_q[i]) <<< DLO) + TW'(s7_pl_q[i]);
        s8_p2_q[i] <= (TW'(s7_ps_q[i][2]) <<< (2*CHK)) + (TW'(s7_ps_q[i][1]) <<< CHK)
                      + TW'(s7_ps_q[i][0]);
        s8_p3_q[i] <= (TW'(s7_pt_q[i][2]) <<< (2*CHK)) + (TW'(s7_pt_q[i][1]) <<< CHK)
                      + TW'(s7_pt_q[i][0]);

        // The bias of 2^31 divisors keeps the quotient unsigned.
        s9_x_q[i] <= s8_p1_q[i] + s8_p2_q[i];
        s9_y_q[i] <= s8_p3_q[i] + TW'(s8_den_q) + (TW'(s8_den_q) <<< QW);

        s10_nb_q[i] <= s9_x_q[i] + s9_y_q[i];
      end

      s2_a_q <= ABW'(s1_aa_q[0]) + ABW'(s1_aa_q[1]) + ABW'(s1_aa_q[2]);
      s2_b_q <= ABW'(s1_ab_q[0]) + ABW'(s1_ab_q[1]) + ABW'(s1_ab_q[2]);
      s2_c_q <= ABW'(s1_bb_q[0]) + ABW'(s1_bb_q[1]) + ABW'(s1_bb_q[2]);

      s3_a_q  <= s2_a_q;
      s3_b_q  <= s2_b_q;
      s3_c_q  <= s2_c_q;
      s3_d_q  <= DEW'(s2_wd_q[0]) + DEW'(s2_wd_q[1]) + DEW'(s2_wd_q[2]);
      s3_e_q  <= DEW'(s2_we_q[0]) + DEW'(s2_we_q[1]) + DEW'(s2_we_q[2]);
      s3_ac_q <= MW'(s2_a_q) * MW'(s2_c_q);
      s3_bb_q <= MW'(s2_b_q) * MW'(s2_b_q);

      s4_den_q   <= DENW'(s3_ac_q - s3_bb_q);
      s4_be_lo_q <= PPW'(s3_b_q) * PPW'(e_lo);
      s4_be_hi_q <= PPW'(s3_b_q) * PPW'(e_hi);
      s4_cd_lo_q <= PPW'(s3_c_q) * PPW'(d_lo);
      s4_cd_hi_q <= PPW'(s3_c_q) * PPW'(d_hi);
      s4_ae_lo_q <= PPW'(s3_a_q) * PPW'(e_lo);
      s4_ae_hi_q <= PPW'(s3_a_q) * PPW'(e_hi);
      s4_bd_lo_q <= PPW'(s3_b_q) * PPW'(d_lo);
      s4_bd_hi_q <= PPW'(s3_b_q) * PPW'(d_hi);

      s5_den_q <= s4_den_q;
      s5_be_q  <= (PRW'(s4_be_hi_q) <<< SPLW) + PRW'(s4_be_lo_q);
      s5_cd_q  <= (PRW'(s4_cd_hi_q) <<< SPLW) + PRW'(s4_cd_lo_q);
      s5_ae_q  <= (PRW'(s4_ae_hi_q) <<< SPLW) + PRW'(s4_ae_lo_q);
      s5_bd_q  <= (PRW'(s4_bd_hi_q) <<< SPLW) + PRW'(s4_bd_lo_q);

      s6_den_q <= s5_den_q;
      s6_sn_q  <= SNW'(s5_be_q) - SNW'(s5_cd_q);
      s6_tn_q  <= SNW'(s5_ae_q) - SNW'(s5_bd_q);

      s7_den_q  <= s6_den_q;
      s8_den_q  <= s7_den_q;
      s9_den_q  <= s8_den_q;
      s10_den_q <= s9_den_q;
    end
  end

  // One quotient bit per step, most significant first.
  always_comb begin
    trial = '0;
    for (int j = 0; j <= QW; j++) begin
      for (int i = 0; i < NAX; i++) begin
        dv_rem_d[j][i] = dv_rem_q[j][i];
        dv_quo_d[j][i] = dv_quo_q[j][i];
      end
    end
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < NAX; i++) begin
        trial = {1'b0, dv_rem_q[j][i]}
                - {1'b0, RW'({dv_d_q[j], {QW{1'b0}}} >> (j + 1))};
        dv_rem_d[j+1][i] = trial[RW] ? dv_rem_q[j][i] : trial[RW-1:0];
        dv_quo_d[j+1][i] = {dv_quo_q[j][i][QW-2:0], ~trial[RW]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NAX; i++) begin
        dv_rem_q[0][i]  <= s10_nb_q[i][RW-1:0];
        dv_quo_q[0][i]  <= '0;
        dv_fl_q[0].lo[i] <= s10_nb_q[i][TW-1];
        dv_fl_q[0].hi[i] <= !s10_nb_q[i][TW-1] && ($unsigned(s10_nb_q[i]) >= lim);
      end
      dv_fl_q[0].par <= (s10_den_q == '0) || s10_den_q[DENW-1];
      dv_d_q[0]      <= dvsr;
      for (int j = 1; j <= QW; j++) begin
        for (int i = 0; i < NAX; i++) begin
          dv_rem_q[j][i] <= dv_rem_d[j][i];
          dv_quo_q[j][i] <= dv_quo_d[j][i];
        end
        dv_d_q[j]  <= dv_d_q[j-1];
        dv_fl_q[j] <= dv_fl_q[j-1];
      end
    end
  end

  // Flipping the top bit removes the bias from the quotient.
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      if (dv_fl_q[QW].par) begin
        mid_d[i] = '0;
      end else if (dv_fl_q[QW].lo[i]) begin
        mid_d[i] = MID_MIN;
      end else if (dv_fl_q[QW].hi[i]) begin
        mid_d[i] = MID_MAX;
      end else begin
        mid_d[i] = $signed({~dv_quo_q[QW][i][QW-1], dv_quo_q[QW][i][QW-2:0]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NAX; i++) begin
        mid_q[i] <= mid_d[i];
      end
      par_q  <= dv_fl_q[QW].par;
      clip_q <= !dv_fl_q[QW].par && ((|dv_fl_q[QW].lo) || (|dv_fl_q[QW].hi));
    end
  end

  assign mid_x_o         = mid_q[0];
  assign mid_y_o         = mid_q[1];
  assign mid_z_o         = mid_q[2];
  assign parallel_flag_o = par_q;
  assign clipped_flag_o  = clip_q;

  a_par_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parallel_flag_o |->
      (mid_x_o == '0) && (mid_y_o == '0) && (mid_z_o == '0) && !clipped_flag_o)
    else $error("parallel word carries a non-zero point or a clip flag");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output word");

  a_last_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && en |=> out_valid_o)
    else $error("word in the last divider step did not reach the output");

endmodule

### test/closest_point_two_rays_tb.sv
// ----------------------------------------------------------------------------
// closest_point_two_rays_tb: self-checking bench for the two-line midpoint
// Drives directed line pairs, then random bursts, against a stalling receiver. Each word is
// checked against a wide integer prediction of the rounded, saturated midpoint.
// ----------------------------------------------------------------------------
module closest_point_two_rays_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cptr_pkg::*;

  localparam int XW      = 192;
  localparam int N_RAND  = 1800;
  localparam int TAIL    = 60;

  typedef logic signed [XW-1:0] wide_t;

  typedef struct {
    logic signed [PW-1:0] pa [NAX];
    logic signed [DW-1:0] da [NAX];
    logic signed [PW-1:0] pb [NAX];
    logic signed [DW-1:0] db [NAX];
  } line_pair_t;

  typedef struct {
    logic signed [PW-1:0] mid [NAX];
    logic                 par;
    logic                 clip;
  } midpoint_t;

  // Rounded midpoint of the closest points, computed with exact integers.
  function automatic midpoint_t midpoint_of(line_pair_t w);
    midpoint_t r;
    wide_t a, b, c, d, e, wv, den, snum, tnum, twoden, tot, q, rem;
    a = 0; b = 0; c = 0; d = 0; e = 0;
    for (int i = 0; i < NAX; i++) begin
      wv = wide_t'(w.pa[i]) - wide_t'(w.pb[i]);
      a += wide_t'(w.da[i]) * wide_t'(w.da[i]);
      b += wide_t'(w.da[i]) * wide_t'(w.db[i]);
      c += wide_t'(w.db[i]) * wide_t'(w.db[i]);
      d += wv * wide_t'(w.da[i]);
      e += wv * wide_t'(w.db[i]);
    end
    den = a * c - b * b;
    r.clip = 1'b0;
    r.par  = 1'b0;
    if (den <= 0) begin
      for (int i = 0; i < NAX; i++) r.mid[i] = '0;
      r.par = 1'b1;
      return r;
    end
    snum   = b * e - c * d;
    tnum   = a * e - b * d;
    twoden = den + den;
    for (int i = 0; i < NAX; i++) begin
      tot = (wide_t'(w.pa[i]) + wide_t'(w.pb[i])) * den + snum * wide_t'(w.da[i])
            + tnum * wide_t'(w.db[i]) + den;
      q   = tot / twoden;
      rem = tot % twoden;
      // Division truncates towards zero, so negative totals need one step down.
      if (rem != 0 && tot < 0) q = q - 1;
      if (q > wide_t'(MID_MAX)) begin
        r.mid[i] = MID_MAX;
        r.clip   = 1'b1;
      end else if (q < wide_t'(MID_MIN)) begin
        r.mid[i] = MID_MIN;
        r.clip   = 1'b1;
      end else begin
        r.mid[i] = q[PW-1:0];
      end
    end
    return r;
  endfunction

  class midpoint_scoreboard;
    midpoint_t pending_q[$];
    int        errors;
    int        words_checked;
    int        parallel_seen;
    int        clipped_seen;

    function void note_input(line_pair_t w);
      pending_q.push_back(midpoint_of(w));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(midpoint_t got);
      midpoint_t want;
      if (pending_q.size() == 0) begin
        report("output word with nothing outstanding");
        return;
      end
      want = pending_q.pop_front();
      words_checked++;
      if (want.par) parallel_seen++;
      if (want.clip) clipped_seen++;
      for (int i = 0; i < NAX; i++)
        if (got.mid[i] !== want.mid[i])
          report($sformatf("word %0d axis %0d mid %h expected %h",
                           words_checked, i, got.mid[i], want.mid[i]));
      if (got.par !== want.par)
        report($sformatf("word %0d parallel_flag %b expected %b",
                         words_checked, got.par, want.par));
      if (got.clip !== want.clip)
        report($sformatf("word %0d clipped_flag %b expected %b",
                         words_checked, got.clip, want.clip));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [PW-1:0] pa_x_i = '0, pa_y_i = '0, pa_z_i = '0;
  logic signed [PW-1:0] pb_x_i = '0, pb_y_i = '0, pb_z_i = '0;
  logic signed [DW-1:0] da_x_i = '0, da_y_i = '0, da_z_i = '0;
  logic signed [DW-1:0] db_x_i = '0, db_y_i = '0, db_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [PW-1:0] mid_x_o, mid_y_o, mid_z_o;
  logic parallel_flag_o, clipped_flag_o;

  midpoint_scoreboard sb = new();

  closest_point_two_rays dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver stall pattern: four modes in turn, from no stall to dense random stalls.
  int unsigned stall_cnt = 0;
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    case ((stall_cnt >> 7) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 30);
      2: out_stall_i <= ((stall_cnt % 16) < 9);
      default: out_stall_i <= ($urandom_range(0, 99) < 70);
    endcase
  end

  always @(posedge clk_i) begin
    midpoint_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.mid[0] = mid_x_o;
      got.mid[1] = mid_y_o;
      got.mid[2] = mid_z_o;
      got.par    = parallel_flag_o;
      got.clip   = clipped_flag_o;
      sb.check_word(got);
    end
  end

  task automatic drive_word(line_pair_t w);
    in_valid_i <= 1'b1;
    pa_x_i <= w.pa[0]; pa_y_i <= w.pa[1]; pa_z_i <= w.pa[2];
    da_x_i <= w.da[0]; da_y_i <= w.da[1]; da_z_i <= w.da[2];
    pb_x_i <= w.pb[0]; pb_y_i <= w.pb[1]; pb_z_i <= w.pb[2];
    db_x_i <= w.db[0]; db_y_i <= w.db[1]; db_z_i <= w.db[2];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
  endtask

  task automatic idle_cycles(int n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic signed [PW-1:0] rand_point(int kind);
    case (kind)
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000);
      default: return $signed(32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000);
    endcase
  endfunction

  function automatic logic signed [DW-1:0] rand_dir(int kind);
    if (kind == 0) return $signed(16'($urandom()));
    return $signed(16'($urandom_range(0, 32768)) - 16'd16384);
  endfunction

  function automatic line_pair_t rand_pair();
    line_pair_t w;
    int pk, dk, shape;
    pk    = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
    dk    = $urandom_range(0, 3) == 0 ? 0 : 1;
    shape = $urandom_range(0, 19);
    for (int i = 0; i < NAX; i++) begin
      w.pa[i] = rand_point(pk);
      w.pb[i] = rand_point(pk);
      w.da[i] = rand_dir(dk);
      w.db[i] = rand_dir(dk);
    end
    // A few words carry parallel, antiparallel or degenerate directions.
    for (int i = 0; i < NAX; i++)
      case (shape)
        0: w.db[i] = w.da[i];
        1: w.db[i] = -w.da[i];
        2: w.da[i] = '0;
        3: w.db[i] = w.da[i] >>> 1;
        default: ;
      endcase
    return w;
  endfunction

  function automatic line_pair_t make_pair(logic signed [PW-1:0] p, logic signed [DW-1:0] d,
                                           logic signed [PW-1:0] q, logic signed [DW-1:0] e);
    line_pair_t w;
    for (int i = 0; i < NAX; i++) begin
      w.pa[i] = p; w.da[i] = d; w.pb[i] = q; w.db[i] = e;
    end
    return w;
  endfunction

  task automatic run_directed();
    line_pair_t w;
    drive_word(make_pair('0, '0, '0, '0));
    drive_word(make_pair(MID_MAX, 16'sh7fff, MID_MAX, 16'sh7fff));
    drive_word(make_pair(MID_MIN, 16'sh8000, MID_MIN, 16'sh8000));
    drive_word(make_pair(MID_MAX, 16'sh4000, MID_MIN, -16'sh4000));
    // Orthogonal unit lines offset along z.
    w = make_pair('0, '0, '0, '0);
    w.da[0] = 16'sh4000; w.db[1] = 16'sh4000; w.pa[2] = 32'sh0001_0000;
    drive_word(w);
    w.pa[0] = MID_MAX; w.pb[1] = MID_MIN;
    drive_word(w);
    // Nearly parallel lines far apart push the midpoint out of range.
    w = make_pair('0, '0, '0, '0);
    w.da[0] = 16'sh7fff; w.db[0] = 16'sh7fff; w.db[1] = 16'sh0001;
    w.pa[1] = MID_MAX; w.pb[1] = MID_MIN;
    drive_word(w);
    w.pa[1] = MID_MIN; w.pb[1] = MID_MAX; w.da[2] = 16'sh8000; w.db[2] = 16'sh8000;
    drive_word(w);
    // Odd sums exercise the rounding tie.
    w = make_pair(32'sh0000_0001, '0, '0, '0);
    w.da[0] = 16'sh4000; w.db[1] = 16'sh4000;
    drive_word(w);
    w.pa[0] = -32'sh0000_0001; w.pa[1] = -32'sh0000_0003;
    drive_word(w);
    drive_word(make_pair(32'sh1234_5678, 16'sh7fff, -32'sh1234_5678, 16'sh8000));
    w = make_pair(32'sh0000_ffff, 16'sh0001, 32'sh7fff_0000, 16'sh0001);
    w.db[2] = -16'sh0001;
    drive_word(w);
    for (int i = 0; i < 6; i++) drive_word(rand_pair());
    idle_cycles(1);
  endtask

  initial begin
    int sent;
    int burst;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();

    sent = 0;
    while (sent < N_RAND) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < N_RAND; k++) begin
        drive_word(rand_pair());
        sent++;
        if (sent == N_RAND / 2) break;
      end
      if (sent == N_RAND / 2) begin
        // Hold off until the pipeline has drained completely.
        in_valid_i <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk_i);
      end else begin
        idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("checked %0d words, %0d parallel and %0d saturated",
             sb.words_checked, sb.parallel_seen, sb.clipped_seen);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
